// ===== hdl/bllca_pkg.sv =====
// bllca_pkg: shared widths, defaults and command codes for the lca engine
// no dependencies; imported by binary_lifting_lca_engine
`timescale 1ns / 1ps

package bllca_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 32;
  localparam int PATH_W  = 33;
  localparam int CNT_W   = 11;
  localparam int STEP_W  = 10;
  localparam int KIND_W  = 2;
  localparam int INFO_W  = DEPTH_W + DIST_W;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int LOG_LEVELS_DEF = 10;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_BUILD = 2'd1;
  localparam kind_t KIND_LCA   = 2'd2;
  localparam kind_t KIND_KTH   = 2'd3;

endpackage

// ===== hdl/bllca_ram.sv =====
// bllca_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the ancestor table and the per-node info store
`timescale 1ns / 1ps

module bllca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/binary_lifting_lca_engine.sv =====
// binary_lifting_lca_engine: lowest common ancestor and k-th ancestor by binary lifting
// depends on bllca_pkg and bllca_ram (ancestor table and node info memories)
//
// Usage: a command beat is taken when start is high and busy is low. kind selects
// load node, build table, lca query or k-th ancestor query. Load beats write the
// node's parent, depth and root distance in the accept cycle; busy stays low.
// Build reads each node's entry, then the entry it names, and writes the next level,
// for every level above level zero, one table ram read port being the limit. A k-th
// ancestor query walks the step bits from the lowest, following the table on each
// set bit. An lca query lifts the deeper node by the depth difference, searches down
// the levels, then reads the final parent and the distances; out of range nodes and
// step counts beyond the table answer at once. Each query gives one result beat:
// done is high for exactly one cycle with answer_node, found and path_distance; the
// receiver cannot stall. node_count is written on the cfg channel (cfg_ready is
// always high); the user must write it only while idle, the block does not enforce
// this. Reset returns the sequencer to idle and node_count to 1; the memories are
// not cleared, so every node must be loaded and the table built before queries.
`timescale 1ns / 1ps

module binary_lifting_lca_engine #(
  parameter int MAX_NODES  = bllca_pkg::MAX_NODES_DEF,
  parameter int LOG_LEVELS = bllca_pkg::LOG_LEVELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bllca_pkg::kind_t               kind,
  input  logic [bllca_pkg::NODE_W-1:0]   node,
  input  logic                           has_parent,
  input  logic [bllca_pkg::NODE_W-1:0]   parent_node,
  input  logic [bllca_pkg::DEPTH_W-1:0]  node_depth,
  input  logic [bllca_pkg::DIST_W-1:0]   root_distance,
  input  logic [bllca_pkg::NODE_W-1:0]   other_node,
  input  logic [bllca_pkg::STEP_W-1:0]   step_count,
  output logic                           done,
  output logic [bllca_pkg::NODE_W-1:0]   answer_node,
  output logic                           found,
  output logic [bllca_pkg::PATH_W-1:0]   path_distance,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bllca_pkg::CNT_W-1:0]    cfg_data
);

  import bllca_pkg::*;

  localparam int NW        = $clog2(MAX_NODES);
  localparam int EW        = NW + 1;
  localparam int LVW       = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
  localparam int TAB_DEPTH = LOG_LEVELS * (2 ** NW);
  localparam int TAW       = $clog2(TAB_DEPTH);
  localparam int CW        = $clog2(MAX_NODES + 1);
  localparam int SW        = 4;

  localparam logic [SW-1:0] S_IDLE   = 4'd0;
  localparam logic [SW-1:0] S_B_RDV  = 4'd1;
  localparam logic [SW-1:0] S_B_RDP  = 4'd2;
  localparam logic [SW-1:0] S_B_WR   = 4'd3;
  localparam logic [SW-1:0] S_L_IV   = 4'd4;
  localparam logic [SW-1:0] S_L_ORD  = 4'd5;
  localparam logic [SW-1:0] S_C_SCAN = 4'd6;
  localparam logic [SW-1:0] S_C_WAIT = 4'd7;
  localparam logic [SW-1:0] S_L_RDA  = 4'd8;
  localparam logic [SW-1:0] S_L_RDB  = 4'd9;
  localparam logic [SW-1:0] S_L_CMP  = 4'd10;
  localparam logic [SW-1:0] S_L_FINA = 4'd11;
  localparam logic [SW-1:0] S_L_FINB = 4'd12;
  localparam logic [SW-1:0] S_L_DREQ = 4'd13;
  localparam logic [SW-1:0] S_L_DIST = 4'd14;

  function automatic logic [TAW-1:0] tab_addr(input logic [LVW-1:0] l,
                                              input logic [NW-1:0] n);
    tab_addr = TAW'({l, n});
  endfunction

  logic [SW-1:0]      state;
  logic [NW-1:0]      cur;
  logic [NW-1:0]      oth;
  logic [STEP_W-1:0]  k_rem;
  logic [LVW-1:0]     lvl;
  logic               lca_mode;
  logic [EW-1:0]      a_hold;
  logic               a_zero;
  logic [DEPTH_W-1:0] du;
  logic [DIST_W-1:0]  ru;
  logic [PATH_W-1:0]  sum_uv;
  logic [CW-1:0]      vcnt;
  logic [CW-1:0]      n_lim;
  logic [CNT_W-1:0]   node_count;

  logic               accept;
  logic               node_ok;
  logic               other_ok;
  logic               parent_ok;
  logic [NW-1:0]      node_idx;
  logic [NW-1:0]      other_idx;
  logic [NW-1:0]      parent_idx;
  logic               load_we;
  logic               step_far;
  logic [CW-1:0]      n_sat;

  logic               tab_we;
  logic [TAW-1:0]     tab_waddr;
  logic [EW-1:0]      tab_wdata;
  logic [TAW-1:0]     tab_raddr;
  logic [EW-1:0]      tab_rdata;
  logic [NW-1:0]      tab_m1;

  logic [NW-1:0]      info_raddr;
  logic [INFO_W-1:0]  info_rdata;
  logic [DIST_W-1:0]  info_dist;
  logic [DEPTH_W-1:0] info_depth;

  logic               swap;
  logic [DEPTH_W-1:0] diff;
  logic               diff_far;
  logic               row_end;

  logic               res_fire;
  logic               res_ok;
  logic [PATH_W-1:0]  res_dist;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign node_ok    = 32'(node) < MAX_NODES;
  assign other_ok   = 32'(other_node) < MAX_NODES;
  assign parent_ok  = 32'(parent_node) < MAX_NODES;
  assign node_idx   = NW'(node);
  assign other_idx  = NW'(other_node);
  assign parent_idx = NW'(parent_node);
  assign load_we    = accept && (kind == KIND_LOAD) && node_ok;
  assign step_far   = (step_count >> LOG_LEVELS) != '0;
  assign n_sat      = (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);

  assign tab_m1     = NW'(tab_rdata - 1'b1);
  assign info_dist  = info_rdata[DIST_W-1:0];
  assign info_depth = info_rdata[INFO_W-1:DIST_W];

  assign swap     = du < info_depth;
  assign diff     = swap ? (info_depth - du) : (du - info_depth);
  assign diff_far = (diff >> LOG_LEVELS) != '0;
  assign row_end  = CW'(vcnt + 1'b1) == n_lim;

  // table ports
  always_comb begin
    tab_we    = load_we || (state == S_B_WR);
    tab_waddr = tab_addr('0, node_idx);
    tab_wdata = (has_parent && parent_ok) ? (EW'(parent_idx) + EW'(1)) : '0;
    if (state == S_B_WR) begin
      tab_waddr = tab_addr(LVW'(lvl + 1'b1), vcnt[NW-1:0]);
      tab_wdata = a_zero ? '0 : tab_rdata;
    end
  end

  always_comb begin
    unique case (state)
      S_B_RDV:  tab_raddr = tab_addr(lvl, vcnt[NW-1:0]);
      S_B_RDP:  tab_raddr = tab_addr(lvl, tab_m1);
      S_L_RDB:  tab_raddr = tab_addr(lvl, oth);
      S_L_FINA: tab_raddr = tab_addr('0, cur);
      default:  tab_raddr = tab_addr(lvl, cur);
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  info_raddr = node_idx;
      S_L_IV:  info_raddr = oth;
      default: info_raddr = cur;
    endcase
  end

  bllca_ram #(
    .WIDTH(EW),
    .DEPTH(TAB_DEPTH)
  ) u_tab_ram (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(tab_wdata),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  bllca_ram #(
    .WIDTH(INFO_W),
    .DEPTH(2 ** NW)
  ) u_info_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(node_idx),
    .wdata({node_depth, root_distance}),
    .raddr(info_raddr),
    .rdata(info_rdata)
  );

  // result decision
  always_comb begin
    res_fire = 1'b0;
    res_ok   = 1'b0;
    res_dist = '0;
    case (state)
      S_IDLE: begin
        if (accept && (kind == KIND_LCA) && !(node_ok && other_ok)) begin
          res_fire = 1'b1;
        end
        if (accept && (kind == KIND_KTH) && (!node_ok || step_far)) begin
          res_fire = 1'b1;
        end
      end
      S_L_ORD: res_fire = diff_far;
      S_C_SCAN: begin
        if (k_rem == '0 && !lca_mode) begin
          res_fire = 1'b1;
          res_ok   = 1'b1;
        end
      end
      S_C_WAIT: res_fire = (tab_rdata == '0);
      S_L_CMP: begin
        res_fire = (a_hold != tab_rdata) && ((a_hold == '0) || (tab_rdata == '0));
      end
      S_L_FINB: res_fire = (tab_rdata == '0);
      S_L_DIST: begin
        res_fire = 1'b1;
        res_ok   = 1'b1;
        res_dist = sum_uv - {info_dist, 1'b0};
      end
      default: res_fire = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      found         <= res_ok;
      answer_node   <= res_ok ? NODE_W'(cur) : '0;
      path_distance <= res_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      node_count <= CNT_W'(1);
    end else begin
      done <= res_fire;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_LOAD: begin
              end
              KIND_BUILD: begin
                n_lim <= n_sat;
                vcnt  <= '0;
                lvl   <= '0;
                if (n_sat != '0 && LOG_LEVELS > 1) begin
                  state <= S_B_RDV;
                end
              end
              KIND_LCA: begin
                cur      <= node_idx;
                oth      <= other_idx;
                lca_mode <= 1'b1;
                if (!res_fire) begin
                  state <= S_L_IV;
                end
              end
              default: begin
                cur      <= node_idx;
                k_rem    <= step_count;
                lvl      <= '0;
                lca_mode <= 1'b0;
                if (!res_fire) begin
                  state <= S_C_SCAN;
                end
              end
            endcase
          end
        end
        S_B_RDV: state <= S_B_RDP;
        S_B_RDP: begin
          a_zero <= (tab_rdata == '0);
          state  <= S_B_WR;
        end
        S_B_WR: begin
          if (row_end) begin
            vcnt <= '0;
            if (lvl == LVW'(LOG_LEVELS - 2)) begin
              state <= S_IDLE;
            end else begin
              lvl   <= LVW'(lvl + 1'b1);
              state <= S_B_RDV;
            end
          end else begin
            vcnt  <= CW'(vcnt + 1'b1);
            state <= S_B_RDV;
          end
        end
        S_L_IV: begin
          du    <= info_depth;
          ru    <= info_dist;
          state <= S_L_ORD;
        end
        S_L_ORD: begin
          sum_uv <= {1'b0, ru} + {1'b0, info_dist};
          if (swap) begin
            cur <= oth;
            oth <= cur;
          end
          k_rem <= STEP_W'(diff);
          lvl   <= '0;
          state <= res_fire ? S_IDLE : S_C_SCAN;
        end
        S_C_SCAN: begin
          if (k_rem == '0) begin
            if (!lca_mode) begin
              state <= S_IDLE;
            end else if (cur == oth) begin
              state <= S_L_DREQ;
            end else begin
              lvl   <= LVW'(LOG_LEVELS - 1);
              state <= S_L_RDA;
            end
          end else if (k_rem[0]) begin
            state <= S_C_WAIT;
          end else begin
            k_rem <= k_rem >> 1;
            lvl   <= LVW'(lvl + 1'b1);
          end
        end
        S_C_WAIT: begin
          if (res_fire) begin
            state <= S_IDLE;
          end else begin
            cur   <= tab_m1;
            k_rem <= k_rem >> 1;
            lvl   <= LVW'(lvl + 1'b1);
            state <= S_C_SCAN;
          end
        end
        S_L_RDA: state <= S_L_RDB;
        S_L_RDB: begin
          a_hold <= tab_rdata;
          state  <= S_L_CMP;
        end
        S_L_CMP: begin
          if (res_fire) begin
            state <= S_IDLE;
          end else begin
            if (a_hold != tab_rdata) begin
              cur <= NW'(a_hold - 1'b1);
              oth <= tab_m1;
            end
            if (lvl == '0) begin
              state <= S_L_FINA;
            end else begin
              lvl   <= LVW'(lvl - 1'b1);
              state <= S_L_RDA;
            end
          end
        end
        S_L_FINA: state <= S_L_FINB;
        S_L_FINB: begin
          if (res_fire) begin
            state <= S_IDLE;
          end else begin
            cur   <= tab_m1;
            state <= S_L_DREQ;
          end
        end
        S_L_DREQ: state <= S_L_DIST;
        S_L_DIST: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // climb never runs past the top table level while step bits remain
  a_scan_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_C_SCAN && k_rem != '0) |-> (32'(lvl) < LOG_LEVELS))
    else $error("climb level out of table range");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while sequencer busy");

  a_build_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_WR) |-> (vcnt < n_lim))
    else $error("build write beyond node range");

  a_build_nocollide: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_WR) |-> (tab_waddr != tab_raddr))
    else $error("build write collides with table read");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for binary_lifting_lca_engine, random trees loaded, built and queried
// keeps its own ancestor table to predict each answer beat; depends on bllca_pkg and the engine
`timescale 1ns / 1ps

module tb;
  import bllca_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int LVLS  = LOG_LEVELS_DEF;

  typedef enum logic [1:0] {ACT_CMD, ACT_CFG, ACT_DRAIN, ACT_PACE} act_e;

  typedef struct packed {
    act_e               act;
    kind_t              kind;
    logic [NODE_W-1:0]  node;
    logic               has_par;
    logic [NODE_W-1:0]  par;
    logic [DEPTH_W-1:0] dep;
    logic [DIST_W-1:0]  rdist;
    logic [NODE_W-1:0]  other;
    logic [STEP_W-1:0]  steps;
    logic [31:0]        value;
  } cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              found;
    logic [PATH_W-1:0] path;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  kind_t kind = KIND_LOAD;
  logic [NODE_W-1:0] node = '0;
  logic has_parent = 1'b0;
  logic [NODE_W-1:0] parent_node = '0;
  logic [DEPTH_W-1:0] node_depth = '0;
  logic [DIST_W-1:0] root_distance = '0;
  logic [NODE_W-1:0] other_node = '0;
  logic [STEP_W-1:0] step_count = '0;
  logic done;
  logic [NODE_W-1:0] answer_node;
  logic found;
  logic [PATH_W-1:0] path_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  cmd_t    cmd_q[$];
  answer_t answer_q[$];
  cmd_t    cur = '0;
  int      errors = 0;
  int      idle_pct = 0;
  int      hold_cnt = 0;

  // tracked engine state: table entries hold parent + 1, zero for none
  logic [NODE_W:0]    lift_tab [LVLS][NODES];
  logic [DEPTH_W-1:0] depth_mem [NODES];
  logic [DIST_W-1:0]  dist_mem [NODES];
  logic [CNT_W-1:0]   count_reg = CNT_W'(1);

  // tree shape as generated, used to aim the k-th ancestor steps
  int                gen_dep [NODES];
  logic [DIST_W-1:0] gen_dist [NODES];
  int                lbl [NODES];

  binary_lifting_lca_engine DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .node(node),
    .has_parent(has_parent), .parent_node(parent_node), .node_depth(node_depth),
    .root_distance(root_distance), .other_node(other_node), .step_count(step_count),
    .done(done), .answer_node(answer_node), .found(found), .path_distance(path_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [NODE_W:0] climb_from(logic [NODE_W-1:0] v, logic [STEP_W-1:0] k);
    logic [NODE_W-1:0] at;
    int i;
    at = v;
    for (i = 0; i < LVLS; i++) begin
      if (k[i]) begin
        if (lift_tab[i][at] == 0) return '0;
        at = NODE_W'(lift_tab[i][at] - 1'b1);
      end
    end
    return {1'b0, at} + 1'b1;
  endfunction

  function automatic logic [NODE_W:0] common_ancestor(logic [NODE_W-1:0] u,
                                                      logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] a, b, t;
    logic [NODE_W:0] r, pa, pb;
    int k;
    a = u;
    b = v;
    if (depth_mem[a] < depth_mem[b]) begin
      t = a;
      a = b;
      b = t;
    end
    r = climb_from(a, depth_mem[a] - depth_mem[b]);
    if (r == 0) return '0;
    a = NODE_W'(r - 1'b1);
    if (a == b) return {1'b0, a} + 1'b1;
    for (k = LVLS - 1; k >= 0; k--) begin
      pa = lift_tab[k][a];
      pb = lift_tab[k][b];
      if (pa != pb) begin
        if (pa == 0 || pb == 0) return '0;
        a = NODE_W'(pa - 1'b1);
        b = NODE_W'(pb - 1'b1);
      end
    end
    return lift_tab[0][a];
  endfunction

  task automatic answer_command(cmd_t c);
    logic [NODE_W:0] w;
    logic [NODE_W-1:0] lca;
    logic [63:0] du, dv, dw;
    answer_t ans;
    int n, lv, v;
    ans = '0;
    case (c.kind)
      KIND_LOAD: begin
        lift_tab[0][c.node] = c.has_par ? {1'b0, c.par} + 1'b1 : '0;
        depth_mem[c.node] = c.dep;
        dist_mem[c.node] = c.rdist;
      end
      KIND_BUILD: begin
        n = int'(count_reg);
        if (n > NODES) n = NODES;
        for (lv = 0; lv + 1 < LVLS; lv++) begin
          for (v = 0; v < n; v++) begin
            w = lift_tab[lv][v];
            lift_tab[lv + 1][v] = (w == 0) ? '0 : lift_tab[lv][w - 1];
          end
        end
      end
      KIND_LCA: begin
        w = common_ancestor(c.node, c.other);
        if (w != 0) begin
          lca = NODE_W'(w - 1'b1);
          du = 64'(dist_mem[c.node]);
          dv = 64'(dist_mem[c.other]);
          dw = 64'(dist_mem[lca]);
          ans.node = lca;
          ans.found = 1'b1;
          ans.path = PATH_W'(du + dv - (dw << 1));
        end
        answer_q.push_back(ans);
      end
      default: begin
        w = climb_from(c.node, c.steps);
        if (w != 0) begin
          ans.node = NODE_W'(w - 1'b1);
          ans.found = 1'b1;
        end
        answer_q.push_back(ans);
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic free, go_start, go_cfg;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      count_reg = CNT_W'(1);
      hold_cnt = 0;
      idle_pct = 0;
    end else begin
      free = 1'b1;
      if (start) begin
        if (!busy) answer_command(cur);
        else free = 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_ready) count_reg = cur.value[CNT_W-1:0];
        else free = 1'b0;
      end
      go_start = 1'b0;
      go_cfg = 1'b0;
      if (!free) begin
        go_start = start;
        go_cfg = cfg_valid;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (cmd_q.size() > 0) begin
        case (cmd_q[0].act)
          ACT_PACE: begin
            idle_pct = cmd_q[0].value;
            void'(cmd_q.pop_front());
          end
          ACT_DRAIN: begin
            if (answer_q.size() == 0 && !busy && !start) begin
              hold_cnt = 16;
              void'(cmd_q.pop_front());
            end
          end
          default: begin
            if ($urandom_range(0, 99) >= idle_pct) begin
              cur = cmd_q.pop_front();
              go_start = (cur.act == ACT_CMD);
              go_cfg = (cur.act == ACT_CFG);
            end
          end
        endcase
      end
      start <= go_start;
      cfg_valid <= go_cfg;
      kind <= cur.kind;
      node <= cur.node;
      has_parent <= cur.has_par;
      parent_node <= cur.par;
      node_depth <= cur.dep;
      root_distance <= cur.rdist;
      other_node <= cur.other;
      step_count <= cur.steps;
      cfg_data <= cur.value[CNT_W-1:0];
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $display("%0t: answer beat with none pending: node %0d found %0b path %0d",
                 $time, answer_node, found, path_distance);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (answer_node !== want.node) begin
          $display("%0t: answer_node expected %0d got %0d", $time, want.node, answer_node);
          errors++;
        end
        if (found !== want.found) begin
          $display("%0t: found expected %0b got %0b", $time, want.found, found);
          errors++;
        end
        if (path_distance !== want.path) begin
          $display("%0t: path_distance expected %0d got %0d", $time, want.path,
                   path_distance);
          errors++;
        end
      end
    end
  end

  function automatic cmd_t noise_cmd(kind_t k);
    cmd_t c;
    c.act = ACT_CMD;
    c.kind = k;
    c.node = NODE_W'($urandom);
    c.has_par = 1'($urandom);
    c.par = NODE_W'($urandom);
    c.dep = DEPTH_W'($urandom);
    c.rdist = $urandom;
    c.other = NODE_W'($urandom);
    c.steps = STEP_W'($urandom);
    c.value = '0;
    return c;
  endfunction

  function automatic cmd_t load_beat(int nd, int hp, int par, int dep, logic [31:0] rd);
    cmd_t c;
    c = noise_cmd(KIND_LOAD);
    c.node = NODE_W'(nd);
    c.has_par = 1'(hp);
    c.par = NODE_W'(par);
    c.dep = DEPTH_W'(dep);
    c.rdist = rd;
    return c;
  endfunction

  function automatic cmd_t lca_beat(int u, int v);
    cmd_t c;
    c = noise_cmd(KIND_LCA);
    c.node = NODE_W'(u);
    c.other = NODE_W'(v);
    return c;
  endfunction

  function automatic cmd_t kth_beat(int u, int k);
    cmd_t c;
    c = noise_cmd(KIND_KTH);
    c.node = NODE_W'(u);
    c.steps = STEP_W'(k);
    return c;
  endfunction

  function automatic cmd_t ctl_beat(act_e a, int unsigned val);
    cmd_t c;
    c = '0;
    c.act = a;
    c.value = val;
    return c;
  endfunction

  // shapes: 0 random, 1 chain, 2 star, 3 heap-like binary
  task automatic grow_tree(int n, int shape, bit noisy, bit wide);
    int i, j, t, p, hp;
    for (i = 0; i < n; i++) lbl[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = lbl[i];
      lbl[i] = lbl[j];
      lbl[j] = t;
    end
    for (i = 0; i < n; i++) begin
      if (i == 0) begin
        hp = 0;
        p = $urandom_range(0, NODES - 1);
        gen_dep[lbl[0]] = 0;
        gen_dist[lbl[0]] = wide ? $urandom : 0;
      end else begin
        case (shape)
          0: j = $urandom_range(0, i - 1);
          1: j = i - 1;
          2: j = 0;
          default: j = (i - 1) / 2;
        endcase
        hp = 1;
        p = lbl[j];
        gen_dep[lbl[i]] = gen_dep[p] + 1;
        gen_dist[lbl[i]] = gen_dist[p] + (wide ? $urandom : $urandom_range(0, 100));
      end
      if (noisy && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: hp = 0;
          1: gen_dep[lbl[i]] = $urandom_range(0, NODES - 1);
          default: begin
            hp = 1;
            p = $urandom_range(0, n - 1);
          end
        endcase
      end
      cmd_q.push_back(load_beat(lbl[i], hp, p, gen_dep[lbl[i]], gen_dist[lbl[i]]));
    end
  endtask

  // rewrite nodes already covered by the table with arbitrary links inside that range
  task automatic scramble_loads(int count, int span);
    int i, u;
    for (i = 0; i < count; i++) begin
      u = $urandom_range(0, span - 1);
      gen_dep[u] = $urandom_range(0, NODES - 1);
      cmd_q.push_back(load_beat(u, $urandom_range(0, 1), $urandom_range(0, span - 1),
                                gen_dep[u], $urandom));
    end
  endtask

  task automatic add_queries(int count, int n, int m);
    int i, u, span, lim;
    for (i = 0; i < count; i++) begin
      span = (n == 0 || $urandom_range(0, 7) == 0) ? m : n;
      u = $urandom_range(0, span - 1);
      if ($urandom_range(0, 1)) begin
        cmd_q.push_back(lca_beat(u, ($urandom_range(0, 5) == 0) ? u
                                                               : $urandom_range(0, span - 1)));
      end else begin
        lim = gen_dep[u] + 1;
        if (lim > NODES - 1) lim = NODES - 1;
        cmd_q.push_back(kth_beat(u, ($urandom_range(0, 3) == 0) ? $urandom_range(0, NODES - 1)
                                                               : $urandom_range(0, lim)));
      end
    end
  endtask

  initial begin : stimulus
    int ph, n, m, guard;
    int pace_pct [4];
    pace_pct = '{0, 84, 0, 32};

    // node_count left at its reset value: a lone root
    cmd_q.push_back(ctl_beat(ACT_PACE, 0));
    cmd_q.push_back(load_beat(0, 0, NODES - 1, 0, 32'hFFFF_FFFF));
    cmd_q.push_back(noise_cmd(KIND_BUILD));
    cmd_q.push_back(lca_beat(0, 0));
    cmd_q.push_back(kth_beat(0, 1));

    // hand-built tree; node 6 sits closer to the root than its parent
    cmd_q.push_back(ctl_beat(ACT_DRAIN, 0));
    cmd_q.push_back(ctl_beat(ACT_CFG, 8));
    cmd_q.push_back(load_beat(7, 1, 2, 2, 32'hFFFF_FFFF));
    cmd_q.push_back(load_beat(6, 1, 2, 2, 0));
    cmd_q.push_back(load_beat(5, 1, 3, 3, 9));
    cmd_q.push_back(load_beat(4, 1, 1, 2, 7));
    cmd_q.push_back(load_beat(3, 1, 1, 2, 8));
    cmd_q.push_back(load_beat(2, 1, 0, 1, 12));
    cmd_q.push_back(load_beat(1, 1, 0, 1, 5));
    cmd_q.push_back(load_beat(0, 0, 0, 0, 0));
    cmd_q.push_back(noise_cmd(KIND_BUILD));
    cmd_q.push_back(lca_beat(5, 4));
    cmd_q.push_back(lca_beat(3, 3));
    cmd_q.push_back(lca_beat(0, 5));
    cmd_q.push_back(lca_beat(5, 7));
    cmd_q.push_back(lca_beat(6, 2));
    cmd_q.push_back(lca_beat(7, 6));
    cmd_q.push_back(kth_beat(5, 0));
    cmd_q.push_back(kth_beat(5, 3));
    cmd_q.push_back(kth_beat(5, 4));
    cmd_q.push_back(kth_beat(7, NODES - 1));
    m = 8;

    for (ph = 0; ph < 14; ph++) begin
      cmd_q.push_back(ctl_beat(ACT_DRAIN, 0));
      cmd_q.push_back(ctl_beat(ACT_PACE, pace_pct[ph % 4]));
      case (ph)
        4: begin
          // full-size chain, deepest possible climbs
          n = NODES;
          cmd_q.push_back(ctl_beat(ACT_CFG, NODES));
          grow_tree(n, 1, 1'b0, 1'b1);
        end
        5: begin
          // count above the table size saturates
          n = NODES;
          cmd_q.push_back(ctl_beat(ACT_CFG, (1 << CNT_W) - 1));
          scramble_loads(16, m);
        end
        6: begin
          // zero count: build leaves the upper levels as they were
          n = 0;
          cmd_q.push_back(ctl_beat(ACT_CFG, 0));
          scramble_loads(8, m);
        end
        9: begin
          n = 1;
          cmd_q.push_back(ctl_beat(ACT_CFG, 1));
          grow_tree(n, 0, 1'b0, 1'b0);
        end
        default: begin
          n = $urandom_range(2, 48);
          cmd_q.push_back(ctl_beat(ACT_CFG, n));
          grow_tree(n, $urandom_range(0, 3), ph % 3 == 2, $urandom_range(0, 1));
        end
      endcase
      cmd_q.push_back(noise_cmd(KIND_BUILD));
      if (n > m) m = n;
      add_queries((ph == 4) ? 40 : 30, n, m);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start || cfg_valid) @(posedge clk);
    guard = 0;
    while (answer_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d answer beats never arrived", $time, answer_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bllca_pkg.sv
hdl/bllca_ram.sv
hdl/binary_lifting_lca_engine.sv
verif/tb.sv
